[hw/rtl/length_prefix_deframer_defines.svh]
// ----------------------------------------------------------------------------
// length_prefix_deframer_defines.svh
// assertion macros used by the deframer rtl
// ----------------------------------------------------------------------------
`ifndef LENGTH_PREFIX_DEFRAMER_DEFINES_SVH
`define LENGTH_PREFIX_DEFRAMER_DEFINES_SVH

// same-cycle implication, checked while out of reset
`define LPD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked while out of reset
`define LPD_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/lpd_pkg.sv]
// ----------------------------------------------------------------------------
// lpd_pkg
// types and constants of the length-prefixed frame deframer
// ----------------------------------------------------------------------------
package lpd_pkg;

	// number of big-endian length bytes in a frame header (1 to 8)
	localparam int LEN_BYTES = 8;
	localparam int HDR_CNT_W = 3;
	localparam int BYTE_W = 8;
	localparam int FRAME_LEN_W = 64;
	localparam int KIND_W = 2;

	typedef enum logic [1:0] {
		PH_HEADER  = 2'd0,
		PH_PAYLOAD = 2'd1,
		PH_TRAILER = 2'd2,
		PH_RESYNC  = 2'd3
	} phase_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_PAYLOAD = 2'd0,
		KIND_END_OK  = 2'd1,
		KIND_END_BAD = 2'd2
	} kind_t;

	typedef struct packed {
		logic                   valid;
		kind_t                  kind;
		logic [BYTE_W-1:0]      data_byte;
		logic                   last_payload;
		logic [FRAME_LEN_W-1:0] frame_length;
	} result_t;

endpackage

[hw/rtl/lpd_stream_if.sv]
// ----------------------------------------------------------------------------
// lpd_stream_if
// valid/ready channels: received byte stream and decoded frame results
// ----------------------------------------------------------------------------
interface lpd_byte_if;
	logic                       valid;
	logic                       ready;
	logic [lpd_pkg::BYTE_W-1:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink (input valid, input in_byte, output ready);
endinterface

interface lpd_frame_if;
	logic                            valid;
	logic                            ready;
	logic [lpd_pkg::KIND_W-1:0]      kind;
	logic [lpd_pkg::BYTE_W-1:0]      data_byte;
	logic                            last_payload;
	logic [lpd_pkg::FRAME_LEN_W-1:0] frame_length;

	modport source (output valid, output kind, output data_byte, output last_payload,
		output frame_length, input ready);
	modport sink (input valid, input kind, input data_byte, input last_payload,
		input frame_length, output ready);
endinterface

[hw/rtl/length_prefix_deframer.sv]
// ----------------------------------------------------------------------------
// length_prefix_deframer
// length-prefixed frame decoder for a received byte stream
// ----------------------------------------------------------------------------
// usage:
//   rx takes one byte per request: eight big-endian length bytes, then that
//   many payload bytes, then a trailer byte that must be zero.
//   frm gives one request per payload byte (last_payload on the final one)
//   and one end request per trailer with the frame length and ok/bad status.
//   header bytes and bytes dropped during resync give no request.
// path: a byte taken from rx sits in the input register, is decoded and is
//   loaded into the result register when it advances, and its result is
//   then offered on frm until the receiver takes it.
// throughput: one byte per cycle unless frm stalls, set by the phase update
//   and the 64-bit payload countdown between the input and result registers.
// stall: while frm holds a result that is not taken, a byte that gives a
//   result waits in the input register and rx drops ready; header and
//   resync bytes still flow through.
// reset: arst_n clears both valid flags and returns the decoder to the
//   header phase with an empty length.
// ----------------------------------------------------------------------------
module length_prefix_deframer (
	input  logic        clk,
	input  logic        arst_n,
	lpd_byte_if.sink    rx,
	lpd_frame_if.source frm
);

	logic                       valid_s1;
	logic [lpd_pkg::BYTE_W-1:0] byte_s1;
	logic                       advance;
	logic                       out_busy;
	logic                       rx_take;
	lpd_pkg::result_t           res;

	assign advance = valid_s1 && (!res.valid || !out_busy);
	assign rx.ready = !valid_s1 || advance;
	assign rx_take = rx.valid && rx.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_take) begin
			byte_s1 <= rx.in_byte;
		end
	end

	lpd_frame_fsm u_fsm (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (advance),
		.rx_byte_s1 (byte_s1),
		.res        (res)
	);

	lpd_out_reg u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (advance && res.valid),
		.res    (res),
		.busy   (out_busy),
		.frm    (frm)
	);

endmodule

[hw/rtl/lpd_frame_fsm.sv]
// ----------------------------------------------------------------------------
// lpd_frame_fsm
// frame phase tracking, length capture and payload countdown
// ----------------------------------------------------------------------------
`include "length_prefix_deframer_defines.svh"

module lpd_frame_fsm (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       step,
	input  logic [lpd_pkg::BYTE_W-1:0] rx_byte_s1,
	output lpd_pkg::result_t           res
);

	lpd_pkg::phase_t                   phase_q, phase_d;
	logic [lpd_pkg::HDR_CNT_W-1:0]     hdr_cnt_q, hdr_cnt_d;
	logic [lpd_pkg::FRAME_LEN_W-1:0]   remaining_q, remaining_d;
	logic [lpd_pkg::FRAME_LEN_W-1:0]   length_q, length_d;
	logic [lpd_pkg::FRAME_LEN_W-1:0]   length_shift;
	logic                              hdr_last;
	logic                              pay_last;
	logic                              byte_zero;

	// first header byte starts a fresh length
	assign length_shift = {(hdr_cnt_q == '0) ? {(lpd_pkg::FRAME_LEN_W-lpd_pkg::BYTE_W){1'b0}}
		: length_q[lpd_pkg::FRAME_LEN_W-lpd_pkg::BYTE_W-1:0], rx_byte_s1};
	assign hdr_last = (hdr_cnt_q == lpd_pkg::HDR_CNT_W'(lpd_pkg::LEN_BYTES - 1));
	assign pay_last = (remaining_q <= lpd_pkg::FRAME_LEN_W'(1));
	assign byte_zero = (rx_byte_s1 == '0);

	always_comb begin
		phase_d = phase_q;
		hdr_cnt_d = hdr_cnt_q;
		remaining_d = remaining_q;
		length_d = length_q;
		if (step) begin
			unique case (phase_q)
				lpd_pkg::PH_HEADER: begin
					length_d = length_shift;
					if (hdr_last) begin
						hdr_cnt_d = '0;
						remaining_d = length_shift;
						phase_d = (length_shift == '0) ? lpd_pkg::PH_TRAILER : lpd_pkg::PH_PAYLOAD;
					end else begin
						hdr_cnt_d = hdr_cnt_q + lpd_pkg::HDR_CNT_W'(1);
					end
				end
				lpd_pkg::PH_PAYLOAD: begin
					remaining_d = pay_last ? '0 : remaining_q - lpd_pkg::FRAME_LEN_W'(1);
					if (pay_last) begin
						phase_d = lpd_pkg::PH_TRAILER;
					end
				end
				lpd_pkg::PH_TRAILER: begin
					phase_d = byte_zero ? lpd_pkg::PH_HEADER : lpd_pkg::PH_RESYNC;
					hdr_cnt_d = '0;
					remaining_d = '0;
				end
				lpd_pkg::PH_RESYNC: begin
					if (byte_zero) begin
						phase_d = lpd_pkg::PH_HEADER;
						hdr_cnt_d = '0;
					end
				end
			endcase
		end
	end

	always_comb begin
		res = '0;
		res.kind = lpd_pkg::KIND_PAYLOAD;
		unique case (phase_q)
			lpd_pkg::PH_PAYLOAD: begin
				res.valid = 1'b1;
				res.data_byte = rx_byte_s1;
				res.last_payload = pay_last;
			end
			lpd_pkg::PH_TRAILER: begin
				res.valid = 1'b1;
				res.kind = byte_zero ? lpd_pkg::KIND_END_OK : lpd_pkg::KIND_END_BAD;
				res.frame_length = length_q;
			end
			lpd_pkg::PH_HEADER, lpd_pkg::PH_RESYNC: begin
				res.valid = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= lpd_pkg::PH_HEADER;
			hdr_cnt_q <= '0;
			remaining_q <= '0;
			length_q <= '0;
		end else begin
			phase_q <= phase_d;
			hdr_cnt_q <= hdr_cnt_d;
			remaining_q <= remaining_d;
			length_q <= length_d;
		end
	end

	`LPD_ASSERT_IMP(a_hdr_cnt_phase, clk, arst_n, hdr_cnt_q != '0, phase_q == lpd_pkg::PH_HEADER, "header count outside header phase")
	`LPD_ASSERT_IMP(a_payload_phase, clk, arst_n, res.valid && res.kind == lpd_pkg::KIND_PAYLOAD, phase_q == lpd_pkg::PH_PAYLOAD, "payload result outside payload phase")
	`LPD_ASSERT_IMP(a_trailer_end, clk, arst_n, phase_q == lpd_pkg::PH_TRAILER, res.valid && res.kind != lpd_pkg::KIND_PAYLOAD, "trailer byte without end result")
	`LPD_ASSERT_NXT(a_resync_exit, clk, arst_n, step && phase_q == lpd_pkg::PH_RESYNC && byte_zero, phase_q == lpd_pkg::PH_HEADER && hdr_cnt_q == '0, "resync did not return to header")

endmodule

[hw/rtl/lpd_out_reg.sv]
// ----------------------------------------------------------------------------
// lpd_out_reg
// result register driving the frame result channel
// ----------------------------------------------------------------------------
module lpd_out_reg (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  lpd_pkg::result_t res,
	output logic             busy,
	lpd_frame_if.source      frm
);

	logic                            valid_q;
	lpd_pkg::kind_t                  kind_q;
	logic [lpd_pkg::BYTE_W-1:0]      data_q;
	logic                            last_q;
	logic [lpd_pkg::FRAME_LEN_W-1:0] len_q;

	// result still waiting for the receiver
	assign busy = valid_q && !frm.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (frm.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			kind_q <= res.kind;
			data_q <= res.data_byte;
			last_q <= res.last_payload;
			len_q <= res.frame_length;
		end
	end

	assign frm.valid = valid_q;
	assign frm.kind = kind_q;
	assign frm.data_byte = data_q;
	assign frm.last_payload = last_q;
	assign frm.frame_length = len_q;

endmodule

[bench/tb_length_prefix_deframer.sv]
// ----------------------------------------------------------------------------
// tb_length_prefix_deframer
// self-checking bench for the length-prefixed frame deframer: a short table of
// hand-checked frames, then random well-formed frames mixed with bad trailers
// and resync noise, under several idle/stall mixes on both channels
// ----------------------------------------------------------------------------
module tb_length_prefix_deframer;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int DRAIN_IDLE = 3000;
	localparam int RAND_ITEMS = 1300;
	localparam int TAIL_PAYLOAD = 20;

	typedef enum logic [1:0] {
		ROW_MODEL,
		ROW_NONE,
		ROW_RES
	} row_chk_t;

	typedef struct packed {
		logic [lpd_pkg::BYTE_W-1:0] b;
		row_chk_t                   chk;
		lpd_pkg::result_t           res;
	} stim_row_t;

	localparam int DIR_ROWS = 21;

	// zero-length frame, one-byte frame with bad trailer, then resync noise
	localparam stim_row_t DIR_TAB [DIR_ROWS] = '{
		'{8'h00, ROW_NONE, '0},
		'{8'h00, ROW_NONE, '0},
		'{8'h00, ROW_NONE, '0},
		'{8'h00, ROW_NONE, '0},
		'{8'h00, ROW_NONE, '0},
		'{8'h00, ROW_NONE, '0},
		'{8'h00, ROW_NONE, '0},
		'{8'h00, ROW_NONE, '0},
		'{8'h00, ROW_RES, '{1'b1, lpd_pkg::KIND_END_OK, 8'h00, 1'b0, 64'd0}},
		'{8'h00, ROW_NONE, '0},
		'{8'h00, ROW_NONE, '0},
		'{8'h00, ROW_NONE, '0},
		'{8'h00, ROW_NONE, '0},
		'{8'h00, ROW_NONE, '0},
		'{8'h00, ROW_NONE, '0},
		'{8'h00, ROW_NONE, '0},
		'{8'h01, ROW_NONE, '0},
		'{8'hFF, ROW_RES, '{1'b1, lpd_pkg::KIND_PAYLOAD, 8'hFF, 1'b1, 64'd0}},
		'{8'h80, ROW_RES, '{1'b1, lpd_pkg::KIND_END_BAD, 8'h00, 1'b0, 64'd1}},
		'{8'h7F, ROW_MODEL, '0},
		'{8'h00, ROW_MODEL, '0}
	};

	logic clk;
	logic arst_n;

	lpd_byte_if  rx_if ();
	lpd_frame_if frm_if ();

	length_prefix_deframer i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_if),
		.frm    (frm_if)
	);

	// predictor state
	lpd_pkg::phase_t               dec_phase;
	logic [lpd_pkg::HDR_CNT_W-1:0] dec_hdr_cnt;
	logic [63:0]                   dec_remain;
	logic [63:0]                   dec_len;

	lpd_pkg::result_t pending_results[$];
	int unsigned      mismatch_cnt;
	int unsigned      src_idle_pct;
	int unsigned      snk_stall_pct;
	int unsigned      items_sent;
	int unsigned      quiet_cycles;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic report_mismatch(input string what);
		mismatch_cnt++;
		$display("tb: mismatch at %0t: %s", $time, what);
	endtask

	function automatic lpd_pkg::result_t deframe_step(input logic [lpd_pkg::BYTE_W-1:0] b);
		lpd_pkg::result_t r;
		r = '0;
		case (dec_phase)
			lpd_pkg::PH_HEADER: begin
				if (dec_hdr_cnt == '0)
					dec_len = '0;
				dec_len = {dec_len[55:0], b};
				dec_hdr_cnt = dec_hdr_cnt + 1'b1;
				// the count wraps to zero when all eight bytes are in
				if (dec_hdr_cnt == lpd_pkg::HDR_CNT_W'(lpd_pkg::LEN_BYTES)) begin
					dec_hdr_cnt = '0;
					dec_remain = dec_len;
					dec_phase = (dec_len == '0) ? lpd_pkg::PH_TRAILER : lpd_pkg::PH_PAYLOAD;
				end
			end
			lpd_pkg::PH_PAYLOAD: begin
				r.valid = 1'b1;
				r.kind = lpd_pkg::KIND_PAYLOAD;
				r.data_byte = b;
				r.last_payload = (dec_remain <= 64'd1);
				if (r.last_payload) begin
					dec_remain = '0;
					dec_phase = lpd_pkg::PH_TRAILER;
				end else begin
					dec_remain = dec_remain - 64'd1;
				end
			end
			lpd_pkg::PH_TRAILER: begin
				r.valid = 1'b1;
				r.kind = (b == '0) ? lpd_pkg::KIND_END_OK : lpd_pkg::KIND_END_BAD;
				r.frame_length = dec_len;
				dec_phase = (b == '0) ? lpd_pkg::PH_HEADER : lpd_pkg::PH_RESYNC;
				dec_hdr_cnt = '0;
				dec_remain = '0;
			end
			default: begin
				if (b == '0) begin
					dec_phase = lpd_pkg::PH_HEADER;
					dec_hdr_cnt = '0;
				end
			end
		endcase
		return r;
	endfunction

	// one request on rx; the expectation is queued once the byte is taken
	task automatic send_byte(input logic [lpd_pkg::BYTE_W-1:0] b, input row_chk_t chk,
			input lpd_pkg::result_t typed);
		lpd_pkg::result_t pred;
		while ($urandom_range(99) < src_idle_pct) begin
			rx_if.valid <= 1'b0;
			@(posedge clk);
		end
		rx_if.valid <= 1'b1;
		rx_if.in_byte <= b;
		@(posedge clk);
		while (!rx_if.ready)
			@(posedge clk);
		pred = deframe_step(b);
		if (chk != ROW_MODEL)
			pred = typed;
		if (pred.valid)
			pending_results.push_back(pred);
	endtask

	task automatic send_frame();
		logic [63:0]                flen;
		logic [lpd_pkg::BYTE_W-1:0] trailer;
		int unsigned                roll;
		int unsigned                noise;
		roll = $urandom_range(99);
		if (roll < 3)
			flen = 64'($urandom_range(290, 256));
		else if (roll < 20)
			flen = 64'($urandom_range(40, 13));
		else
			flen = 64'($urandom_range(12, 0));
		for (int i = lpd_pkg::LEN_BYTES - 1; i >= 0; i--)
			send_byte(flen[8*i +: 8], ROW_MODEL, '0);
		for (int unsigned i = 0; i < flen; i++)
			send_byte(lpd_pkg::BYTE_W'($urandom_range(255)), ROW_MODEL, '0);
		trailer = ($urandom_range(99) < 85) ? 8'h00
			: lpd_pkg::BYTE_W'($urandom_range(255, 1));
		send_byte(trailer, ROW_MODEL, '0);
		items_sent += lpd_pkg::LEN_BYTES + 32'(flen) + 1;
		// bad trailer: junk until a zero byte brings the decoder back
		if (trailer != 8'h00) begin
			noise = $urandom_range(5);
			repeat (noise)
				send_byte(lpd_pkg::BYTE_W'($urandom_range(255, 1)), ROW_MODEL, '0);
			send_byte(8'h00, ROW_MODEL, '0);
			items_sent += noise + 1;
		end
	endtask

	// hold rx idle until every queued result has come out
	task automatic wait_drained();
		rx_if.valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		frm_if.ready = 1'b0;
		forever begin
			@(posedge clk);
			frm_if.ready <= arst_n && ($urandom_range(99) >= snk_stall_pct);
		end
	end

	always @(posedge clk) begin
		lpd_pkg::result_t want;
		if (arst_n && frm_if.valid && frm_if.ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("unexpected request kind %0d", frm_if.kind));
			end else begin
				want = pending_results.pop_front();
				if (frm_if.kind !== want.kind)
					report_mismatch($sformatf("kind %0d, want %0d", frm_if.kind, want.kind));
				if (frm_if.data_byte !== want.data_byte)
					report_mismatch($sformatf("data_byte %h, want %h",
						frm_if.data_byte, want.data_byte));
				if (frm_if.last_payload !== want.last_payload)
					report_mismatch($sformatf("last_payload %b, want %b",
						frm_if.last_payload, want.last_payload));
				if (frm_if.frame_length !== want.frame_length)
					report_mismatch($sformatf("frame_length %0d, want %0d",
						frm_if.frame_length, want.frame_length));
			end
		end
	end

	// watchdog: too long without any request taken on either side
	always @(posedge clk) begin
		if ((rx_if.valid && rx_if.ready) || (frm_if.valid && frm_if.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= DRAIN_IDLE) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		rx_if.valid = 1'b0;
		rx_if.in_byte = '0;
		mismatch_cnt = 0;
		items_sent = 0;
		quiet_cycles = 0;
		src_idle_pct = 0;
		snk_stall_pct = 0;
		dec_phase = lpd_pkg::PH_HEADER;
		dec_hdr_cnt = '0;
		dec_remain = '0;
		dec_len = '0;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIR_TAB[i])
			send_byte(DIR_TAB[i].b, DIR_TAB[i].chk, DIR_TAB[i].res);

		for (int p = 0; p < 4; p++) begin
			case (p)
				0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
				1: begin src_idle_pct = 54; snk_stall_pct = 0;  end
				2: begin src_idle_pct = 0;  snk_stall_pct = 54; end
				default: begin src_idle_pct = 32; snk_stall_pct = 32; end
			endcase
			wait_drained();
			while (items_sent < RAND_ITEMS * (p + 1) / 4)
				send_frame();
		end

		// longest possible length: the frame never ends, so it goes last
		for (int i = 0; i < lpd_pkg::LEN_BYTES; i++)
			send_byte(8'hFF, ROW_MODEL, '0);
		repeat (TAIL_PAYLOAD)
			send_byte(lpd_pkg::BYTE_W'($urandom_range(255)), ROW_MODEL, '0);

		wait_drained();
		repeat (8) @(posedge clk);
		if (mismatch_cnt == 0 && pending_results.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/lpd_pkg.sv
hw/rtl/lpd_stream_if.sv
hw/rtl/lpd_frame_fsm.sv
hw/rtl/lpd_out_reg.sv
hw/rtl/length_prefix_deframer.sv
bench/tb_length_prefix_deframer.sv
